// ----- hw/rtl/canflt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canflt_pkg
// Shared types and constants for the CAN receive identifier/mask filter table.
// ----------------------------------------------------------------------------
package canflt_pkg;

    localparam int ID_W    = 11;
    localparam int KEY_W   = 12;
    localparam int RTR_POS = 11;
    localparam int EIDX_W  = 5;
    localparam int CFG_W   = 6;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RST = 6'd32;

    localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ILLEGAL = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        t_key ident;
        t_key mask;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- hw/rtl/can_rx_id_mask_filter_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rx_id_mask_filter_table
// CAN receive acceptance table: entry writes and first-match frame lookup.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_ready   command, entry and frame fields
//   result    out        o_out_valid / i_out_ready status, matched, index, batch_end
//   config    in         APB psel/penable/pwrite   entries_in_use
//
// A write request goes from idle straight to done. A match request scans
// the entries in order up to and including the first hit (at most the
// entries in use); the walk reads one RAM entry per cycle.
// Reset is synchronous; per-entry valid bits make unwritten entries read as
// ident 0, mask all ones, no handler. A stalled result holds the walk's end.
// ----------------------------------------------------------------------------
module can_rx_id_mask_filter_table #(
    parameter int ENTRIES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_command,
    input  logic [4:0]                     i_entry_index,
    input  logic [10:0]                    i_filter_ident,
    input  logic [10:0]                    i_filter_mask,
    input  logic                           i_filter_rtr,
    input  logic                           i_handler_present,
    input  logic [10:0]                    i_frame_ident,
    input  logic                           i_frame_rtr,
    input  logic                           i_last_of_batch,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_status,
    output logic                           o_matched,
    output logic [4:0]                     o_match_index,
    output logic                           o_batch_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [canflt_pkg::ADDR_W-1:0]  paddr,
    input  logic [canflt_pkg::DATA_W-1:0]  pwdata,
    output logic [canflt_pkg::DATA_W-1:0]  prdata,
    output logic                           pready
);

    import canflt_pkg::*;

    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW_MIN  = $clog2(ENTRIES + 1);
    localparam int CW      = (CW_MIN > CFG_W) ? CW_MIN : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic [ENTRIES-1:0] r_vld;
    logic               r_rd_vld;
    logic [IW-1:0]      r_cmp_idx;
    t_key               r_key;
    logic               r_res_status;
    logic               r_res_matched;
    logic [EIDX_W-1:0]  r_res_index;
    logic               r_res_batch;
    logic               r_out_valid;
    logic               r_out_status;
    logic               r_out_matched;
    logic [EIDX_W-1:0]  r_out_index;
    logic               r_out_batch;

    logic [CFG_W-1:0]   cfg_entries;
    logic [CW-1:0]      cfg_ext;
    logic [CW-1:0]      eff_count;
    logic               accept;
    logic               wr_legal;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    t_entry             ram_rdata;
    t_key               cur_ident;
    t_key               cur_mask;
    logic               hit;
    logic               last;
    logic               out_free;
    t_key               n_key;

    canflt_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_entries_in_use (cfg_entries)
    );

    canflt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cfg_ext   = CW'(cfg_entries);
    assign eff_count = (cfg_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cfg_ext;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign wr_legal   = (CW'(i_entry_index) < eff_count) && i_handler_present;

    assign ram_we          = accept && (i_command == CMD_WRITE) && wr_legal;
    assign ram_waddr       = IW'(i_entry_index);
    assign ram_wdata.ident = {i_filter_rtr, i_filter_ident};
    assign ram_wdata.mask  = {1'b1, i_filter_mask};

    assign n_key = {i_frame_rtr, i_frame_ident};

    assign cur_ident = r_rd_vld ? ram_rdata.ident : '0;
    assign cur_mask  = r_rd_vld ? ram_rdata.mask : '1;
    assign hit       = ((r_key ^ cur_ident) & cur_mask) == '0;
    assign last      = (CW'(r_cmp_idx) + CW'(1)) == eff_count;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            ST_IDLE: begin
                ram_re = accept && (i_command == CMD_MATCH) && (eff_count != '0);
            end
            ST_SCAN: begin
                ram_re    = !hit && !last;
                ram_raddr = r_cmp_idx + IW'(1);
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_vld[ram_raddr];
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_key         <= n_key;
                        r_cmp_idx     <= '0;
                        r_res_matched <= 1'b0;
                        r_res_index   <= '0;
                        if (i_command == CMD_WRITE) begin
                            r_res_status <= wr_legal ? STATUS_OK : STATUS_ILLEGAL;
                            r_res_batch  <= 1'b0;
                            r_state      <= ST_DONE;
                        end else begin
                            r_res_status <= STATUS_OK;
                            r_res_batch  <= i_last_of_batch;
                            r_state      <= (eff_count != '0) ? ST_SCAN : ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        r_res_matched <= r_rd_vld;
                        r_res_index   <= EIDX_W'(r_cmp_idx);
                        r_state       <= ST_DONE;
                    end else if (last) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cmp_idx <= r_cmp_idx + IW'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_status  <= r_res_status;
                        r_out_matched <= r_res_matched;
                        r_out_index   <= r_res_index;
                        r_out_batch   <= r_res_batch;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_matched     = r_out_matched;
    assign o_match_index = r_out_index;
    assign o_batch_end   = r_out_batch;

endmodule

// ----- hw/rtl/canflt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canflt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module canflt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/canflt_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canflt_regs
// APB configuration register file: entries_in_use at byte address 0.
// ----------------------------------------------------------------------------
module canflt_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [canflt_pkg::ADDR_W-1:0]  paddr,
    input  logic [canflt_pkg::DATA_W-1:0]  pwdata,
    output logic [canflt_pkg::DATA_W-1:0]  prdata,
    output logic                           pready,
    output logic [canflt_pkg::CFG_W-1:0]   o_entries_in_use
);

    import canflt_pkg::*;

    logic [CFG_W-1:0] r_entries_in_use;
    logic             wr_hit;
    logic             reg_sel;

    assign reg_sel = (paddr[ADDR_W-1] == REG_ENTRIES_IN_USE);
    assign wr_hit  = psel && penable && pwrite && reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= ENTRIES_IN_USE_RST;
        end else if (wr_hit) begin
            r_entries_in_use <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata           = reg_sel ? DATA_W'(r_entries_in_use) : '0;
    assign pready           = 1'b1;
    assign o_entries_in_use = r_entries_in_use;

endmodule

// ----- tb/can_rx_id_mask_filter_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rx_id_mask_filter_table_tb
// Self-checking bench for the CAN receive identifier/mask filter table.
// Requests go in through a valid/ready channel and results are checked in
// order against a table model kept in the bench. Directed requests cover
// unwritten entries, refused writes, RTR compare and first-match-without-
// handler. The entry count is then swept over its extremes, the output is
// held off long enough to stall the input, and random traffic follows, mostly
// frames built to hit stored entries. Both sides idle at random.
// ----------------------------------------------------------------------------
module can_rx_id_mask_filter_table_tb;
    import canflt_pkg::*;

    localparam int TABLE_ENTRIES    = 32;
    localparam int SETTLE_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_PRINTED      = 100;
    localparam logic [ADDR_W-1:0] ENTRIES_IN_USE_ADDR = ADDR_W'(4 * REG_ENTRIES_IN_USE);

    typedef struct packed {
        logic              cmd;
        logic [EIDX_W-1:0] idx;
        logic [ID_W-1:0]   flt_ident;
        logic [ID_W-1:0]   flt_mask;
        logic              flt_rtr;
        logic              handler;
        logic [ID_W-1:0]   frm_ident;
        logic              frm_rtr;
        logic              last_batch;
    } t_request;

    typedef struct packed {
        logic              status;
        logic              matched;
        logic [EIDX_W-1:0] index;
        logic              batch_end;
    } t_result;

    localparam int REQ_W = $bits(t_request);

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_command = 1'b0;
    logic [4:0]        i_entry_index = '0;
    logic [10:0]       i_filter_ident = '0;
    logic [10:0]       i_filter_mask = '0;
    logic              i_filter_rtr = 1'b0;
    logic              i_handler_present = 1'b0;
    logic [10:0]       i_frame_ident = '0;
    logic              i_frame_rtr = 1'b0;
    logic              i_last_of_batch = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_status;
    logic              o_matched;
    logic [4:0]        o_match_index;
    logic              o_batch_end;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_key              tbl_ident [TABLE_ENTRIES] = '{default: '0};
    t_key              tbl_mask [TABLE_ENTRIES] = '{default: '1};
    logic              tbl_handler [TABLE_ENTRIES] = '{default: 1'b0};
    logic [CFG_W-1:0]  cfg_entries = ENTRIES_IN_USE_RST;

    t_result           pending_results [$];
    int unsigned       mismatches = 0;
    int unsigned       idle_cycles = 0;
    bit                no_idle = 1'b0;
    bit                hold_off_go = 1'b0;

    can_rx_id_mask_filter_table #(
        .ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_entry_index    (i_entry_index),
        .i_filter_ident   (i_filter_ident),
        .i_filter_mask    (i_filter_mask),
        .i_filter_rtr     (i_filter_rtr),
        .i_handler_present(i_handler_present),
        .i_frame_ident    (i_frame_ident),
        .i_frame_rtr      (i_frame_rtr),
        .i_last_of_batch  (i_last_of_batch),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_matched        (o_matched),
        .o_match_index    (o_match_index),
        .o_batch_end      (o_batch_end),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED) begin
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic int active_entries();
        return (int'(cfg_entries) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg_entries);
    endfunction

    function automatic t_result filter_lookup(input t_request r);
        t_result res;
        t_key    key;
        int      n;
        res = '0;
        n = active_entries();
        if (r.cmd == CMD_WRITE) begin
            if (int'(r.idx) < n && r.handler) begin
                tbl_ident[r.idx]   = {r.flt_rtr, r.flt_ident};
                tbl_mask[r.idx]    = {1'b1, r.flt_mask};
                tbl_handler[r.idx] = 1'b1;
                res.status = STATUS_OK;
            end else begin
                res.status = STATUS_ILLEGAL;
            end
        end else begin
            key = {r.frm_rtr, r.frm_ident};
            res.status = STATUS_OK;
            for (int i = 0; i < n; i++) begin
                if (((key ^ tbl_ident[i]) & tbl_mask[i]) == '0) begin
                    res.matched = tbl_handler[i];
                    res.index   = EIDX_W'(i);
                    break;
                end
            end
            res.batch_end = r.last_batch;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_request noise_request();
        return t_request'(REQ_W'({$urandom, $urandom}));
    endfunction

    function automatic t_request write_req(input logic [4:0] idx, input logic [10:0] ident,
                                           input logic [10:0] mask, input logic rtr,
                                           input logic handler);
        t_request r;
        r = noise_request();
        r.cmd       = CMD_WRITE;
        r.idx       = idx;
        r.flt_ident = ident;
        r.flt_mask  = mask;
        r.flt_rtr   = rtr;
        r.handler   = handler;
        return r;
    endfunction

    function automatic t_request match_req(input logic [10:0] ident, input logic rtr,
                                           input logic last_batch);
        t_request r;
        r = noise_request();
        r.cmd        = CMD_MATCH;
        r.frm_ident  = ident;
        r.frm_rtr    = rtr;
        r.last_batch = last_batch;
        return r;
    endfunction

    function automatic t_request make_request();
        t_request r;
        t_key     key;
        int       n;
        int       e;
        r = noise_request();
        n = active_entries();
        if ($urandom_range(0, 9) < 3) begin
            r.cmd = CMD_WRITE;
            if (n > 0 && $urandom_range(0, 99) < 85) begin
                r.idx = EIDX_W'($urandom_range(0, n - 1));
            end
            r.handler = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 3))
                0: r.flt_mask = '1;
                1: r.flt_mask = '0;
                2: r.flt_mask = r.flt_mask & ID_W'($urandom);
                default: ;
            endcase
        end else begin
            r.cmd = CMD_MATCH;
            if (n > 0 && $urandom_range(0, 9) < 7) begin
                e = $urandom_range(0, n - 1);
                key = t_key'($urandom);
                key = (tbl_ident[e] & tbl_mask[e]) | (key & ~tbl_mask[e]);
                {r.frm_rtr, r.frm_ident} = key;
            end
            r.last_batch = ($urandom_range(0, 3) == 0);
        end
        return r;
    endfunction

    task automatic send_request(input t_request r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_command         <= r.cmd;
        i_entry_index     <= r.idx;
        i_filter_ident    <= r.flt_ident;
        i_filter_mask     <= r.flt_mask;
        i_filter_rtr      <= r.flt_rtr;
        i_handler_present <= r.handler;
        i_frame_ident     <= r.frm_ident;
        i_frame_rtr       <= r.frm_rtr;
        i_last_of_batch   <= r.last_batch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(filter_lookup(r));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_entries_in_use(input int value);
        logic [DATA_W-1:0] rd;
        wait_idle();
        apb_write(ENTRIES_IN_USE_ADDR, DATA_W'(value));
        cfg_entries = CFG_W'(value);
        apb_read(ENTRIES_IN_USE_ADDR, rd);
        if (rd[CFG_W-1:0] !== cfg_entries) begin
            report_mismatch("entries_in_use readback", int'(rd[CFG_W-1:0]), int'(cfg_entries));
        end
    endtask

    task automatic test_directed_entries();
        send_request(match_req(11'h000, 1'b0, 1'b1));
        send_request(match_req(11'h7FF, 1'b1, 1'b0));
        send_request(write_req(5'd0, 11'h7FF, 11'h7FF, 1'b1, 1'b0));
        send_request(write_req(5'd31, 11'h7FF, 11'h7FF, 1'b1, 1'b1));
        send_request(match_req(11'h7FF, 1'b1, 1'b1));
        send_request(match_req(11'h7FF, 1'b0, 1'b0));
        send_request(write_req(5'd3, 11'h123, 11'h000, 1'b0, 1'b1));
        send_request(match_req(11'h555, 1'b0, 1'b1));
        send_request(match_req(11'h000, 1'b0, 1'b0));
        send_request(write_req(5'd5, 11'h120, 11'h7F0, 1'b1, 1'b1));
        send_request(match_req(11'h12A, 1'b1, 1'b1));
        send_request(match_req(11'h13A, 1'b1, 1'b0));
        send_request(write_req(5'd0, 11'h000, 11'h7FF, 1'b0, 1'b1));
        send_request(match_req(11'h000, 1'b0, 1'b1));
        send_request(write_req(5'd1, 11'h7FF, 11'h000, 1'b1, 1'b1));
        send_request(match_req(11'h001, 1'b1, 1'b0));
    endtask

    task automatic test_entry_count();
        set_entries_in_use(0);
        send_request(write_req(5'd0, 11'h2AA, 11'h7FF, 1'b0, 1'b1));
        send_request(match_req(11'h000, 1'b0, 1'b1));
        set_entries_in_use(63);
        send_request(write_req(5'd31, 11'h7FF, 11'h7FF, 1'b1, 1'b1));
        send_request(match_req(11'h7FF, 1'b1, 1'b1));
        set_entries_in_use(1);
        send_request(write_req(5'd1, 11'h001, 11'h7FF, 1'b0, 1'b1));
        send_request(write_req(5'd0, 11'h001, 11'h7FF, 1'b0, 1'b1));
        send_request(match_req(11'h001, 1'b0, 1'b0));
        set_entries_in_use(32);
    endtask

    task automatic test_backpressure();
        no_idle     = 1'b1;
        hold_off_go = 1'b1;
        repeat (40) send_request(make_request());
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int counts [7] = '{32, 7, 63, 1, 0, 19, 32};
        int lengths [7] = '{500, 300, 300, 150, 50, 300, 300};
        for (int p = 0; p < 7; p++) begin
            set_entries_in_use(counts[p]);
            no_idle = (p == 2);
            repeat (lengths[p]) send_request(make_request());
        end
        no_idle = 1'b0;
    endtask

    initial begin : ready_driver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off_go) begin
                hold_off_go = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (n - 1) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_matched !== want.matched)
                    report_mismatch("matched", int'(o_matched), int'(want.matched));
                if (o_match_index !== want.index)
                    report_mismatch("match_index", int'(o_match_index), int'(want.index));
                if (o_batch_end !== want.batch_end)
                    report_mismatch("batch_end", int'(o_batch_end), int'(want.batch_end));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("can_rx_id_mask_filter_table: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_entries();
        test_entry_count();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_results.size());
        end
        if (mismatches == 0) begin
            $display("can_rx_id_mask_filter_table: match");
        end else begin
            $display("can_rx_id_mask_filter_table: mismatch");
        end
        $finish;
    end

endmodule
